>>> hdl/ccgd_pkg.sv
// Package with the grid geometry, fixed-point widths and shared types of the charge deposit core.
`default_nettype none
package ccgd_pkg;

  localparam int GRID_N   = 32;
  localparam int COORD_W  = $clog2(GRID_N);
  localparam int ADDR_W   = 3 * COORD_W;
  localparam int CELLS    = GRID_N * GRID_N * GRID_N;

  localparam int POS_W    = 24;
  localparam int SCALE_W  = 24;
  localparam int PROD_W   = POS_W + SCALE_W;
  localparam int FRAC_W   = 14;
  localparam int WT_W     = FRAC_W + 1;
  localparam int WXY_W    = 2 * FRAC_W + 1;
  localparam int WXYZ_W   = 3 * FRAC_W + 1;
  localparam int Q_W      = 16;
  localparam int QW_W     = Q_W + WXYZ_W;
  localparam int ACC_W    = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
  localparam logic [WT_W-1:0]    ONE_Q14     = WT_W'(16384);

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_DEPOSIT = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  typedef struct packed {
    logic                    en;
    logic [ADDR_W-1:0]       addr;
    logic signed [ACC_W-1:0] data;
  } grid_wr_t;

endpackage
`default_nettype wire

>>> hdl/cic_charge_grid_deposit_core.sv
// Top level of the cloud-in-cell charge deposit core with its control and accumulate pipeline.
`default_nettype none
// Deposits point charges onto a periodic GRID_N^3 grid held in one memory. A deposit item
// passes through a split state that scales the position, then a read-modify-write started for
// each of the eight corners on the memory's read and write ports, then a drain of the accumulate
// pipeline before the next item can be taken. A read item returns its result through the read
// and result states; a deposit or clear may be accepted while that result waits. Clear items
// and reset sweep all GRID_N^3 (32768) entries with zeros, one entry a cycle, during which no
// item is accepted. Configuration writes are taken at any time.
module cic_charge_grid_deposit_core
  import ccgd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [SCALE_W-1:0]      cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              op,
  input  wire logic [POS_W-1:0]        pos_x,
  input  wire logic [POS_W-1:0]        pos_y,
  input  wire logic [POS_W-1:0]        pos_z,
  input  wire logic signed [Q_W-1:0]   charge,
  input  wire logic [14:0]             cell_index,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [ACC_W-1:0]      cell_value,
  output logic                         saturated
);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_SPLIT   = 7'b0000100,
    ST_DEPOSIT = 7'b0001000,
    ST_DRAIN   = 7'b0010000,
    ST_READ    = 7'b0100000,
    ST_RESULT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [SCALE_W-1:0]    grid_scale;
  logic                  overflow_seen;
  logic [ADDR_W-1:0]     sweep_addr;
  logic [2:0]            corner;

  logic [POS_W-1:0]      px, py, pz;
  logic                  q_neg;
  logic [Q_W-1:0]        q_mag;
  logic [14:0]           rd_index;

  logic [COORD_W-1:0]    cx, cy, cz;
  logic [FRAC_W-1:0]     fx, fy, fz;

  logic [PROD_W-1:0]     prod_x, prod_y, prod_z;

  // Corner pipeline: A forms address and xy weight, B the full weight,
  // C the scaled charge and the memory read, D the saturating write.
  logic [WT_W-1:0]       wx_a, wy_a, wz_a;
  logic [ADDR_W-1:0]     idx_a;
  logic [2*WT_W-1:0]     wxy_a;

  logic                  vb, vc, vd;
  logic [ADDR_W-1:0]     idx_b, idx_c, idx_d;
  logic [WXY_W-1:0]      wxy_b;
  logic [WT_W-1:0]       wz_b;
  logic [WXYZ_W-1:0]     w_c;
  logic [Q_W-1:0]        mag_d;
  logic [QW_W-1:0]       qw_c;

  logic signed [Q_W:0]   add_d;
  logic signed [ACC_W:0] sum_d;
  logic signed [ACC_W-1:0] sat_d;
  logic                  ovf_d;

  grid_wr_t              wr;
  logic [ADDR_W-1:0]     rd_addr;
  logic signed [ACC_W-1:0] rd_data;
  logic                  idx_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grid_scale <= cfg_data;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px       <= pos_x;
      py       <= pos_y;
      pz       <= pos_z;
      q_neg    <= charge[Q_W-1];
      q_mag    <= charge[Q_W-1] ? Q_W'(-charge) : charge;
      rd_index <= cell_index;
    end
  end

  assign prod_x = PROD_W'(px) * PROD_W'(grid_scale);
  assign prod_y = PROD_W'(py) * PROD_W'(grid_scale);
  assign prod_z = PROD_W'(pz) * PROD_W'(grid_scale);

  always_ff @(posedge clk) begin
    if (state == ST_SPLIT) begin
      cx <= prod_x[32 +: COORD_W];
      cy <= prod_y[32 +: COORD_W];
      cz <= prod_z[32 +: COORD_W];
      fx <= prod_x[18 +: FRAC_W];
      fy <= prod_y[18 +: FRAC_W];
      fz <= prod_z[18 +: FRAC_W];
    end
  end

  // Stage A.
  always_comb begin
    wx_a  = corner[2] ? WT_W'(fx) : ONE_Q14 - WT_W'(fx);
    wy_a  = corner[1] ? WT_W'(fy) : ONE_Q14 - WT_W'(fy);
    wz_a  = corner[0] ? WT_W'(fz) : ONE_Q14 - WT_W'(fz);
    idx_a = {COORD_W'(cx + COORD_W'(corner[2])),
             COORD_W'(cy + COORD_W'(corner[1])),
             COORD_W'(cz + COORD_W'(corner[0]))};
    wxy_a = (2*WT_W)'(wx_a) * (2*WT_W)'(wy_a);
  end

  assign qw_c = QW_W'(q_mag) * QW_W'(w_c) + (QW_W'(1) << 41);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      vb <= (state == ST_DEPOSIT);
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    idx_b <= idx_a;
    wxy_b <= wxy_a[WXY_W-1:0];
    wz_b  <= wz_a;
    idx_c <= idx_b;
    w_c   <= WXYZ_W'(wxy_b) * WXYZ_W'(wz_b);
    idx_d <= idx_c;
    mag_d <= qw_c[42 +: Q_W];
  end

  // Stage D: add to the entry read in stage C and saturate.
  always_comb begin
    add_d = q_neg ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});
    sum_d = (ACC_W+1)'(rd_data) + (ACC_W+1)'(add_d);
    ovf_d = (sum_d[ACC_W] != sum_d[ACC_W-1]);
    if (ovf_d) begin
      sat_d = sum_d[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_d = sum_d[ACC_W-1:0];
    end
  end

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = idx_d;
    wr.data = sat_d;
    if (state == ST_CLEAR) begin
      wr.en   = 1'b1;
      wr.addr = sweep_addr;
      wr.data = '0;
    end else if (vd) begin
      wr.en = 1'b1;
    end
  end

  assign rd_addr = vc ? idx_c : rd_index[ADDR_W-1:0];
  assign idx_ok  = ({1'b0, rd_index} < 16'(CELLS));

  ccgd_grid_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sweep_addr == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_CLEAR:   state_next = ST_CLEAR;
            OP_DEPOSIT: state_next = ST_SPLIT;
            OP_READ:    state_next = ST_READ;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SPLIT:   state_next = ST_DEPOSIT;
      ST_DEPOSIT: begin
        if (corner == 3'd7) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!vb && !vc) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ:   state_next = ST_RESULT;
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      sweep_addr    <= '0;
      corner        <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end else begin
        sweep_addr <= '0;
      end
      if (state == ST_DEPOSIT) begin
        corner <= corner + 3'd1;
      end else begin
        corner <= '0;
      end
      if (in_valid && in_ready && op == OP_CLEAR) begin
        overflow_seen <= 1'b0;
      end else if (vd && ovf_d) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Result register; a held result does not block later deposits or clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && (!out_valid || out_ready)) begin
      cell_value <= idx_ok ? rd_data : '0;
      saturated  <= overflow_seen;
    end
  end

  a_ready_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!vb && !vc && !vd))
    else $error("item taken while the accumulate pipeline is busy");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == ST_CLEAR || vd))
    else $error("grid write outside a clear sweep or accumulate stage");

  a_flag_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_seen) |-> $past(vd))
    else $error("saturation flag set without an accumulation");

  a_corner_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && $past(state) == ST_DEPOSIT) |-> $past(corner) == 3'd7)
    else $error("deposit left the corner loop early");

endmodule
`default_nettype wire

>>> hdl/ccgd_grid_mem.sv
// Grid accumulator memory: one write port and one registered read port.
`default_nettype none
module ccgd_grid_mem
  import ccgd_pkg::*;
(
  input  wire logic                    clk,
  input  wire grid_wr_t                wr,
  input  wire logic [ADDR_W-1:0]       rd_addr,
  output logic signed [ACC_W-1:0]      rd_data
);

  logic signed [ACC_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> sim/cic_charge_grid_deposit_core_tb.sv
// Self-checking testbench for the cloud-in-cell charge deposit core.
`timescale 1ns / 100ps
`default_nettype none
module cic_charge_grid_deposit_core_tb;
  import ccgd_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [SCALE_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] op;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;
  logic signed [Q_W-1:0] charge;
  logic [14:0] cell_index;
  logic out_valid;
  logic out_ready;
  logic signed [ACC_W-1:0] cell_value;
  logic saturated;

  typedef struct {
    logic signed [ACC_W-1:0] value;
    logic sat;
  } cell_read_t;

  cell_read_t pending_reads[$];
  logic signed [ACC_W-1:0] grid_model[CELLS];
  logic sat_model;
  logic [SCALE_W-1:0] scale_model;
  int mismatches = 0;
  int idle_cycles;
  bit jitter_on;

  cic_charge_grid_deposit_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .charge(charge), .cell_index(cell_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_value(cell_value), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic split_axis(input logic [POS_W-1:0] pos, output int coord,
                            output logic [FRAC_W:0] frac);
    logic [PROD_W-1:0] prod;
    prod = pos * scale_model;
    coord = prod[47:32] % GRID_N;
    frac = {1'b0, prod[31:18]};
  endtask

  task automatic deposit_charge(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                input logic [POS_W-1:0] z, input logic signed [Q_W-1:0] q);
    int cx, cy, cz, idx;
    logic [FRAC_W:0] fx, fy, fz, wx, wy, wz;
    logic [63:0] w, mag;
    logic [127:0] prod;
    logic [16:0] qmag;
    logic signed [63:0] sum;
    split_axis(x, cx, fx);
    split_axis(y, cy, fy);
    split_axis(z, cz, fz);
    qmag = q[15] ? 17'(-$signed({q[15], q})) : {1'b0, q};
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 2; c++) begin
          wx = a ? fx : ONE_Q14 - fx;
          wy = b ? fy : ONE_Q14 - fy;
          wz = c ? fz : ONE_Q14 - fz;
          w = 64'(wx) * 64'(wy) * 64'(wz);
          prod = 128'(qmag) * 128'(w) + (128'(1) << 41);
          mag = 64'(prod >> 42);
          idx = (((cx + a) % GRID_N) * GRID_N + (cy + b) % GRID_N) * GRID_N
                + (cz + c) % GRID_N;
          sum = 64'(grid_model[idx]) + (q[15] ? -$signed(mag) : $signed(mag));
          if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            sat_model = 1'b1;
          end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            sat_model = 1'b1;
          end
          grid_model[idx] = sum[31:0];
        end
  endtask

  task automatic apply_item(input logic [1:0] o, input logic [14:0] ci,
                            input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [POS_W-1:0] z, input logic signed [Q_W-1:0] q);
    cell_read_t r;
    case (o)
      OP_CLEAR: begin
        foreach (grid_model[i]) grid_model[i] = '0;
        sat_model = 1'b0;
      end
      OP_DEPOSIT: deposit_charge(x, y, z, q);
      OP_READ: begin
        r.value = (ci < CELLS) ? grid_model[ci] : '0;
        r.sat = sat_model;
        pending_reads = {pending_reads, r};
      end
      default: ;
    endcase
  endtask

  task automatic random_gap();
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Sends one item and updates the prediction at acceptance.
  task automatic send_item(input logic [1:0] o, input logic [14:0] ci,
                           input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [POS_W-1:0] z, input logic signed [Q_W-1:0] q);
    random_gap();
    in_valid <= 1'b1;
    op <= o;
    cell_index <= ci;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    charge <= q;
    do @(posedge clk); while (!in_ready);
    apply_item(o, ci, x, y, z, q);
  endtask

  task automatic send_filler(input logic [1:0] o);
    send_item(o, 15'($urandom), POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              Q_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] s);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= s;
    do @(posedge clk); while (!cfg_ready);
    scale_model = s;
    cfg_valid <= 1'b0;
  endtask

  task automatic read_cell(input logic [14:0] ci);
    send_item(OP_READ, ci, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              Q_W'($urandom));
  endtask

  task automatic deposit_one(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [POS_W-1:0] z, input logic signed [Q_W-1:0] q);
    send_item(OP_DEPOSIT, 15'($urandom), x, y, z, q);
  endtask

  task automatic test_directed();
    read_cell(15'd0);
    deposit_one('0, '0, '0, 16'sh7fff);
    deposit_one('1, '1, '1, -16'sh8000);
    deposit_one(24'h018000, 24'h1f4000, 24'h00c000, 16'sh4000);
    read_cell(15'd0);
    read_cell(15'h7fff);
    read_cell(15'h7c00);
    send_item(OP_IGNORED, '1, '1, '1, '1, '1);
    read_cell(15'd1057);
    // Repeated full-weight deposits build up a large value in one cell.
    repeat (12) deposit_one(24'h050000, 24'h050000, 24'h050000, 16'sh7fff);
    read_cell(15'(5 * 1024 + 5 * 32 + 5));
    send_filler(OP_CLEAR);
    read_cell(15'(5 * 1024 + 5 * 32 + 5));
  endtask

  task automatic test_scales();
    write_scale('0);
    deposit_one(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), 16'sh2000);
    read_cell(15'd0);
    write_scale('1);
    deposit_one('1, 24'h000001, 24'h123456, -16'sh1234);
    for (int i = 0; i < 6; i++) read_cell(15'($urandom));
    write_scale(24'h008000);
  endtask

  task automatic test_random();
    logic [14:0] recent[$];
    int kind;
    for (int n = 0; n < 680; n++) begin
      if (n == 600) jitter_on = 1'b0;
      if (n == 300) write_scale(24'(24'h010000 + $urandom_range(0, 24'h30000)));
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        logic [POS_W-1:0] x, y, z;
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        z = POS_W'($urandom);
        deposit_one(x, y, z, Q_W'($urandom));
        recent = {recent, 15'($urandom_range(0, CELLS - 1))};
      end else if (kind < 97) begin
        if (recent.size() != 0 && kind < 85) read_cell(recent.pop_front());
        else read_cell(15'($urandom));
      end else if (kind < 98) begin
        send_filler(OP_CLEAR);
      end else begin
        send_filler(OP_IGNORED);
      end
    end
    write_scale(24'h020000);
    for (int n = 0; n < 20; n++) begin
      deposit_one(POS_W'($urandom_range(0, 24'h0fffff)), POS_W'($urandom),
                  POS_W'($urandom), Q_W'($urandom));
      read_cell(15'($urandom_range(0, 2047)));
    end
  endtask

  // Result checker with random back-pressure.
  always @(posedge clk) begin
    cell_read_t want;
    if (rst) begin
      out_ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("unexpected result", cell_value, 32'h0);
        end else begin
          want = pending_reads.pop_front();
          if (cell_value !== want.value)
            report_mismatch("cell_value", cell_value, want.value);
          if (saturated !== want.sat)
            report_mismatch("saturated", 32'(saturated), 32'(want.sat));
        end
      end
      if (idle_cycles > 0) begin
        out_ready <= 1'b0;
        idle_cycles <= idle_cycles - 1;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        idle_cycles <= $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with no handshake on any channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= OP_CLEAR;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    charge <= '0;
    cell_index <= '0;
    jitter_on = 1'b1;
    sat_model = 1'b0;
    scale_model = SCALE_RESET;
    foreach (grid_model[i]) grid_model[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_scales();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hdl/ccgd_pkg.sv
hdl/ccgd_grid_mem.sv
hdl/cic_charge_grid_deposit_core.sv
sim/cic_charge_grid_deposit_core_tb.sv
